// ----- hdl/gmt_pkg.sv -----
package gmt_pkg;

   // item kinds on the request channel
   localparam logic [1:0] REQ_GOSSIP = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_ACK    = 2'd2;
   localparam logic [1:0] REQ_PROBE  = 2'd3;

   // member status codes
   localparam logic [1:0] MS_ALIVE   = 2'd0;
   localparam logic [1:0] MS_SUSPECT = 2'd1;
   localparam logic [1:0] MS_CONFIRM = 2'd2;
   // gossiped status outside the legal set
   localparam logic [1:0] MS_INVALID = 2'd3;

   // event codes
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_ADD_ACT   = 3'd1;
   localparam logic [2:0] EV_ADD_CONF  = 3'd2;
   localparam logic [2:0] EV_UPDATED   = 3'd3;
   localparam logic [2:0] EV_REFUTED   = 3'd4;
   localparam logic [2:0] EV_MOVED     = 3'd5;
   localparam logic [2:0] EV_FULL      = 3'd6;
   localparam logic [2:0] EV_NOT_FOUND = 3'd7;

   // announce codes
   localparam logic [1:0] AN_NONE    = 2'd0;
   localparam logic [1:0] AN_ALIVE   = 2'd1;
   localparam logic [1:0] AN_SUSPECT = 2'd2;
   localparam logic [1:0] AN_CONFIRM = 2'd3;

   // csr register indexes
   localparam logic REG_SELF_ID = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam int          RESULT_LIMIT   = 16;
   localparam int          RES_W          = 5;
   localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;

   typedef struct packed {
      logic [47:0] id;
      logic [1:0]  status;
      logic [31:0] inc;
      logic [63:0] deadline;
   } entry_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHIFT,
      OP_ROT,
      OP_APPEND,
      OP_UPDATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   data;
      logic        wr_inc;
      logic        wr_dl;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_DECIDE,
      S_DROP,
      S_TICK_A,
      S_TICK_B
   } state_type;

endpackage

// ----- hdl/gmt_cell.sv -----
module gmt_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  logic [CNT_W-1:0]         cnt,
   input  gmt_pkg::cell_ctl_type    ctl,
   input  logic                     sel,
   input  logic [47:0]              key,
   input  gmt_pkg::entry_type       next_entry,
   input  gmt_pkg::entry_type       head_entry,
   output gmt_pkg::entry_type       entry,
   output logic                     match
);

   localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] MY_IDX_1 = CNT_W'(IDX + 1);

   gmt_pkg::entry_type entry_ff, entry_in;

   // id compare, only inside the live part of the list
   assign match = (MY_IDX < cnt) && (entry_ff.id == key);
   assign entry = entry_ff;

   // next entry value
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         gmt_pkg::OP_SHIFT: begin
            entry_in = next_entry;
         end
         gmt_pkg::OP_ROT: begin
            if (MY_IDX_1 < cnt) begin
               entry_in = next_entry;
            end else if (MY_IDX_1 == cnt) begin
               entry_in = head_entry;
            end
         end
         gmt_pkg::OP_APPEND: begin
            if (MY_IDX == cnt) begin
               entry_in = ctl.data;
            end
         end
         gmt_pkg::OP_UPDATE: begin
            if (sel) begin
               entry_in.status = ctl.data.status;
               if (ctl.wr_inc) begin
                  entry_in.inc = ctl.data.inc;
               end
               if (ctl.wr_dl) begin
                  entry_in.deadline = ctl.data.deadline;
               end
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- hdl/gmt_conf_cell.sv -----
module gmt_conf_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic [CNT_W-1:0] cnt,
   input  logic             append,
   input  logic [47:0]      new_id,
   input  logic [47:0]      key,
   output logic             match
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [47:0] id_ff, id_in;

   assign match = (MY_IDX < cnt) && (id_ff == key);

   // write at the fill position
   always_comb begin
      id_in = id_ff;
      if (append && (MY_IDX == cnt)) begin
         id_in = new_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule

// ----- hdl/gossip_membership_table.sv -----
// Gossip, ack and probe items: after accept, a compare state and a decide state lead to the result;
// when a gossiped confirm compacts the list, a drop walk over every active member follows.
// Tick items: every active member is walked through the head of the cell chain.
// One item at a time; the next item is accepted once the previous one has finished.
// Synchronous active-high reset clears counts, state machine and output valid;
// self_id resets to 0 and suspect timeout to 5000 ms.
module gossip_membership_table #(
   parameter int MAX_MEMBERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [47:0] req_member_id,
   input  logic [1:0]  req_member_status,
   input  logic [31:0] req_incarnation,
   input  logic [63:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [47:0] rsp_member_id_res,
   output logic [1:0]  rsp_member_status_res,
   output logic [31:0] rsp_incarnation_res,
   output logic [1:0]  rsp_announce,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MEMBERS);
   localparam logic [gmt_pkg::RES_W-1:0] K_LAST = gmt_pkg::RES_W'(gmt_pkg::RESULT_LIMIT - 1);
   localparam logic [gmt_pkg::RES_W-1:0] K_LIM  = gmt_pkg::RES_W'(gmt_pkg::RESULT_LIMIT);

   // configuration registers
   logic [47:0] self_id_ff;
   logic [31:0] timeout_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff <= '0;
         timeout_ff <= gmt_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[3] == gmt_pkg::REG_SELF_ID) begin
            self_id_ff <= csr_pwdata[47:0];
         end else begin
            timeout_ff <= csr_pwdata[31:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[3] == gmt_pkg::REG_SELF_ID) ? {16'd0, self_id_ff}
                                                               : {32'd0, timeout_ff};

   // control state
   gmt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, ccnt_ff, ccnt_in, steps_ff, steps_in;
   logic [gmt_pkg::RES_W-1:0] k_ff, k_in;

   // captured item
   logic [1:0]  type_ff;
   logic [47:0] key_ff;
   logic [1:0]  st_ff;
   logic [31:0] inc_ff;
   logic [63:0] now_ff;
   logic [63:0] dl_ff;
   logic [MAX_MEMBERS-1:0] match_ff;
   logic        conf_hit_ff;

   // output register
   logic        rsp_valid_ff;
   logic [2:0]  ev_ff;
   logic [47:0] rid_ff;
   logic [1:0]  rst_ff;
   logic [31:0] rinc_ff;
   logic [1:0]  ann_ff;
   logic        last_ff;

   // chain signals
   gmt_pkg::entry_type    ent [MAX_MEMBERS];
   logic [MAX_MEMBERS-1:0] act_match;
   logic [MAX_MEMBERS-1:0] conf_match;
   gmt_pkg::cell_ctl_type ctl;
   logic                  conf_append;
   logic [47:0]           conf_new_id;
   logic [47:0]           conf_key;

   logic accept;
   logic out_free;
   logic emit;
   logic [2:0]  ev_c;
   logic [1:0]  rst_c;
   logic [31:0] rinc_c;
   logic [1:0]  ann_c;
   logic        last_c;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != gmt_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // active member cells
   for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_act
      gmt_pkg::entry_type nxt;
      if (g == MAX_MEMBERS - 1) begin : g_tail
         assign nxt = ent[g];
      end else begin : g_mid
         assign nxt = ent[g + 1];
      end
      gmt_cell #(.IDX(g), .CNT_W(CNT_W)) u_cell (
         .clock      (clock),
         .cnt        (cnt_ff),
         .ctl        (ctl),
         .sel        (match_ff[g]),
         .key        (key_ff),
         .next_entry (nxt),
         .head_entry (ent[0]),
         .entry      (ent[g]),
         .match      (act_match[g])
      );
   end

   // confirmed id cells
   assign conf_key = (state_ff == gmt_pkg::S_TICK_A) ? ent[0].id : key_ff;

   for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_conf
      gmt_conf_cell #(.IDX(g), .CNT_W(CNT_W)) u_conf (
         .clock  (clock),
         .cnt    (ccnt_ff),
         .append (conf_append),
         .new_id (conf_new_id),
         .key    (conf_key),
         .match  (conf_match[g])
      );
   end

   // matched entry, one-hot select
   gmt_pkg::entry_type sel_e;
   logic               found;
   always_comb begin
      sel_e = '0;
      for (int i = 0; i < MAX_MEMBERS; i++) begin
         sel_e = sel_e | (match_ff[i] ? ent[i] : '0);
      end
   end
   assign found = |match_ff;

   // saturating deadline
   logic [64:0] dl_sum;
   assign dl_sum = {1'b0, now_ff} + {33'd0, timeout_ff};

   // tick head examination
   logic head_expired;
   logic tick_emit;
   assign head_expired = (ent[0].status == gmt_pkg::MS_SUSPECT) && (ent[0].deadline < now_ff);
   assign tick_emit    = (k_ff < K_LIM);

   // gossip decision
   logic is_self_refute;
   logic take;
   assign is_self_refute = (key_ff == self_id_ff) && (st_ff == gmt_pkg::MS_SUSPECT);
   always_comb begin
      if (st_ff == gmt_pkg::MS_ALIVE) begin
         take = inc_ff > sel_e.inc;
      end else begin
         take = ((sel_e.status == gmt_pkg::MS_SUSPECT) && (inc_ff > sel_e.inc)) ||
                ((sel_e.status == gmt_pkg::MS_ALIVE) && (inc_ff >= sel_e.inc));
      end
   end

   logic decide_drop;
   assign decide_drop = (type_ff == gmt_pkg::REQ_GOSSIP) && found &&
                        (st_ff == gmt_pkg::MS_CONFIRM) && !is_self_refute;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmt_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (req_type == gmt_pkg::REQ_TICK) ? gmt_pkg::S_TICK_A
                                                           : gmt_pkg::S_MATCH;
            end
         end
         gmt_pkg::S_MATCH: begin
            state_in = gmt_pkg::S_DECIDE;
         end
         gmt_pkg::S_DECIDE: begin
            if (out_free) begin
               state_in = decide_drop ? gmt_pkg::S_DROP : gmt_pkg::S_IDLE;
            end
         end
         gmt_pkg::S_DROP: begin
            if (steps_ff == CNT_W'(1)) begin
               state_in = gmt_pkg::S_IDLE;
            end
         end
         gmt_pkg::S_TICK_A: begin
            state_in = (steps_ff == '0) ? gmt_pkg::S_IDLE : gmt_pkg::S_TICK_B;
         end
         gmt_pkg::S_TICK_B: begin
            if (!tick_emit || out_free) begin
               state_in = (steps_ff == CNT_W'(1)) ? gmt_pkg::S_IDLE : gmt_pkg::S_TICK_A;
            end
         end
         default: begin
            state_in = gmt_pkg::S_IDLE;
         end
      endcase
   end

   // actions per state
   always_comb begin
      ctl         = '0;
      ctl.op      = gmt_pkg::OP_HOLD;
      conf_append = 1'b0;
      conf_new_id = key_ff;
      cnt_in      = cnt_ff;
      ccnt_in     = ccnt_ff;
      steps_in    = steps_ff;
      k_in        = k_ff;
      emit        = 1'b0;
      ev_c        = gmt_pkg::EV_NONE;
      rst_c       = gmt_pkg::MS_ALIVE;
      rinc_c      = '0;
      ann_c       = gmt_pkg::AN_NONE;
      last_c      = 1'b1;
      case (state_ff)
         gmt_pkg::S_IDLE: begin
            if (accept) begin
               steps_in = cnt_ff;
               k_in     = '0;
            end
         end
         gmt_pkg::S_DECIDE: begin
            if (out_free) begin
               emit = 1'b1;
               if (type_ff == gmt_pkg::REQ_GOSSIP) begin
                  if (st_ff == gmt_pkg::MS_INVALID) begin
                     // invalid gossiped status
                     rst_c  = found ? sel_e.status : gmt_pkg::MS_ALIVE;
                     rinc_c = found ? sel_e.inc : '0;
                  end else if (!found) begin
                     if (conf_hit_ff) begin
                        rst_c = gmt_pkg::MS_CONFIRM;
                     end else if (st_ff == gmt_pkg::MS_CONFIRM) begin
                        rst_c  = st_ff;
                        rinc_c = inc_ff;
                        if (ccnt_ff >= CNT_MAX) begin
                           ev_c = gmt_pkg::EV_FULL;
                        end else begin
                           ev_c        = gmt_pkg::EV_ADD_CONF;
                           conf_append = 1'b1;
                           ccnt_in     = ccnt_ff + CNT_W'(1);
                        end
                     end else begin
                        rst_c  = st_ff;
                        rinc_c = inc_ff;
                        if (cnt_ff >= CNT_MAX) begin
                           ev_c = gmt_pkg::EV_FULL;
                        end else begin
                           ev_c                 = gmt_pkg::EV_ADD_ACT;
                           ctl.op               = gmt_pkg::OP_APPEND;
                           ctl.data.id          = key_ff;
                           ctl.data.status      = st_ff;
                           ctl.data.inc         = inc_ff;
                           ctl.data.deadline    = dl_ff;
                           cnt_in               = cnt_ff + CNT_W'(1);
                        end
                     end
                  end else if (is_self_refute) begin
                     ev_c            = gmt_pkg::EV_REFUTED;
                     rst_c           = gmt_pkg::MS_ALIVE;
                     rinc_c          = inc_ff + 32'd1;
                     ann_c           = gmt_pkg::AN_ALIVE;
                     ctl.op          = gmt_pkg::OP_UPDATE;
                     ctl.data.status = gmt_pkg::MS_ALIVE;
                     ctl.data.inc    = inc_ff + 32'd1;
                     ctl.wr_inc      = 1'b1;
                  end else if (st_ff == gmt_pkg::MS_CONFIRM) begin
                     ev_c     = gmt_pkg::EV_MOVED;
                     rst_c    = gmt_pkg::MS_CONFIRM;
                     rinc_c   = inc_ff;
                     ann_c    = gmt_pkg::AN_CONFIRM;
                     steps_in = cnt_ff;
                     if (!conf_hit_ff && (ccnt_ff < CNT_MAX)) begin
                        conf_append = 1'b1;
                        ccnt_in     = ccnt_ff + CNT_W'(1);
                     end
                  end else if (take) begin
                     ev_c              = gmt_pkg::EV_UPDATED;
                     rst_c             = st_ff;
                     rinc_c            = inc_ff;
                     ctl.op            = gmt_pkg::OP_UPDATE;
                     ctl.data.status   = st_ff;
                     ctl.data.inc      = inc_ff;
                     ctl.data.deadline = dl_ff;
                     ctl.wr_inc        = 1'b1;
                     ctl.wr_dl         = 1'b1;
                  end else begin
                     rst_c  = sel_e.status;
                     rinc_c = sel_e.inc;
                  end
               end else if (!found) begin
                  ev_c = gmt_pkg::EV_NOT_FOUND;
               end else if (type_ff == gmt_pkg::REQ_ACK) begin
                  ev_c              = gmt_pkg::EV_UPDATED;
                  rinc_c            = sel_e.inc;
                  ann_c             = (sel_e.status == gmt_pkg::MS_SUSPECT) ? gmt_pkg::AN_ALIVE
                                                                            : gmt_pkg::AN_NONE;
                  ctl.op            = gmt_pkg::OP_UPDATE;
                  ctl.data.status   = gmt_pkg::MS_ALIVE;
                  ctl.data.deadline = dl_ff;
                  ctl.wr_dl         = 1'b1;
               end else if (sel_e.status == gmt_pkg::MS_ALIVE) begin
                  ev_c              = gmt_pkg::EV_UPDATED;
                  rst_c             = gmt_pkg::MS_SUSPECT;
                  rinc_c            = sel_e.inc;
                  ann_c             = gmt_pkg::AN_SUSPECT;
                  ctl.op            = gmt_pkg::OP_UPDATE;
                  ctl.data.status   = gmt_pkg::MS_SUSPECT;
                  ctl.data.deadline = dl_ff;
                  ctl.wr_dl         = 1'b1;
               end else begin
                  rst_c  = sel_e.status;
                  rinc_c = sel_e.inc;
               end
            end
         end
         gmt_pkg::S_DROP: begin
            // walk the list once, dropping the confirmed member
            steps_in = steps_ff - CNT_W'(1);
            if (ent[0].id == key_ff) begin
               ctl.op = gmt_pkg::OP_SHIFT;
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               ctl.op = gmt_pkg::OP_ROT;
            end
         end
         gmt_pkg::S_TICK_B: begin
            if (!tick_emit || out_free) begin
               emit        = tick_emit;
               conf_new_id = ent[0].id;
               rinc_c      = ent[0].inc;
               last_c      = (steps_ff == CNT_W'(1)) || (k_ff == K_LAST);
               steps_in    = steps_ff - CNT_W'(1);
               if (tick_emit) begin
                  k_in = k_ff + gmt_pkg::RES_W'(1);
               end
               if (head_expired) begin
                  ctl.op = gmt_pkg::OP_SHIFT;
                  cnt_in = cnt_ff - CNT_W'(1);
                  ev_c   = gmt_pkg::EV_MOVED;
                  rst_c  = gmt_pkg::MS_CONFIRM;
                  ann_c  = gmt_pkg::AN_CONFIRM;
                  if (!conf_hit_ff && (ccnt_ff < CNT_MAX)) begin
                     conf_append = 1'b1;
                     ccnt_in     = ccnt_ff + CNT_W'(1);
                  end
               end else begin
                  ctl.op = gmt_pkg::OP_ROT;
                  rst_c  = ent[0].status;
               end
            end
         end
         default: begin
            ctl.op = gmt_pkg::OP_HOLD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmt_pkg::S_IDLE;
         cnt_ff   <= '0;
         ccnt_ff  <= '0;
         steps_ff <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ccnt_ff  <= ccnt_in;
         steps_ff <= steps_in;
         k_ff     <= k_in;
      end
   end

   // item capture and compare results
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         key_ff  <= req_member_id;
         st_ff   <= req_member_status;
         inc_ff  <= req_incarnation;
         now_ff  <= req_now_ms;
      end
      if (state_ff == gmt_pkg::S_MATCH) begin
         match_ff <= act_match;
         dl_ff    <= dl_sum[64] ? '1 : dl_sum[63:0];
      end
      if ((state_ff == gmt_pkg::S_MATCH) || (state_ff == gmt_pkg::S_TICK_A)) begin
         conf_hit_ff <= |conf_match;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ev_ff   <= ev_c;
         rid_ff  <= (state_ff == gmt_pkg::S_TICK_B) ? ent[0].id : key_ff;
         rst_ff  <= rst_c;
         rinc_ff <= rinc_c;
         ann_ff  <= ann_c;
         last_ff <= last_c;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_kind        = ev_ff;
   assign rsp_member_id_res     = rid_ff;
   assign rsp_member_status_res = rst_ff;
   assign rsp_incarnation_res   = rinc_ff;
   assign rsp_announce          = ann_ff;
   assign rsp_last              = last_ff;

endmodule

// ----- bench/membership_checker.sv -----
`timescale 1ns / 1ps

module membership_checker #(
   parameter int MAX_MEMBERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [47:0] req_member_id,
   input  logic [1:0]  req_member_status,
   input  logic [31:0] req_incarnation,
   input  logic [63:0] req_now_ms,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_event_kind,
   input  logic [47:0] rsp_member_id_res,
   input  logic [1:0]  rsp_member_status_res,
   input  logic [31:0] rsp_incarnation_res,
   input  logic [1:0]  rsp_announce,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [2:0]  ev;
      logic [47:0] id;
      logic [1:0]  status;
      logic [31:0] inc;
      logic [1:0]  announce;
      logic        last;
   } member_event_type;

   // shadow of the membership table and the registers
   logic [47:0] node_id;
   logic [31:0] timeout_ms;
   logic [47:0] act_id [MAX_MEMBERS];
   logic [1:0]  act_status [MAX_MEMBERS];
   logic [31:0] act_inc [MAX_MEMBERS];
   logic [63:0] act_deadline [MAX_MEMBERS];
   int          act_count;
   logic [47:0] conf_id [MAX_MEMBERS];
   int          conf_count;
   logic [31:0] node_inc;

   member_event_type events_due[$];

   function automatic logic [63:0] deadline_at(logic [63:0] now);
      logic [64:0] sum;
      sum = {1'b0, now} + {33'd0, timeout_ms};
      return sum[64] ? '1 : sum[63:0];
   endfunction

   function automatic int find_member(logic [47:0] id);
      for (int i = 0; i < act_count; i++)
         if (act_id[i] == id)
            return i;
      return -1;
   endfunction

   function automatic bit is_confirmed(logic [47:0] id);
      for (int i = 0; i < conf_count; i++)
         if (conf_id[i] == id)
            return 1;
      return 0;
   endfunction

   task automatic push_event(logic [2:0] ev, logic [47:0] id, logic [1:0] st,
                             logic [31:0] inc, logic [1:0] ann, logic last);
      member_event_type e;
      e.ev = ev; e.id = id; e.status = st; e.inc = inc; e.announce = ann; e.last = last;
      events_due.push_back(e);
   endtask

   // retire entry i into the confirmed list and close the gap
   task automatic retire_member(int i);
      if (!is_confirmed(act_id[i]) && conf_count < MAX_MEMBERS) begin
         conf_id[conf_count] = act_id[i];
         conf_count++;
      end
      for (int j = i; j + 1 < act_count; j++) begin
         act_id[j] = act_id[j + 1];
         act_status[j] = act_status[j + 1];
         act_inc[j] = act_inc[j + 1];
         act_deadline[j] = act_deadline[j + 1];
      end
      act_count--;
   endtask

   task automatic apply_gossip(logic [47:0] id, logic [1:0] st, logic [31:0] inc,
                               logic [63:0] now);
      int  f;
      bit  take;
      f = find_member(id);
      if (st > gmt_pkg::MS_CONFIRM) begin
         if (f < 0)
            push_event(gmt_pkg::EV_NONE, id, gmt_pkg::MS_ALIVE, '0, gmt_pkg::AN_NONE, 1'b1);
         else
            push_event(gmt_pkg::EV_NONE, id, act_status[f], act_inc[f], gmt_pkg::AN_NONE,
                       1'b1);
      end else if (f < 0) begin
         if (is_confirmed(id)) begin
            push_event(gmt_pkg::EV_NONE, id, gmt_pkg::MS_CONFIRM, '0, gmt_pkg::AN_NONE, 1'b1);
         end else if (st == gmt_pkg::MS_CONFIRM) begin
            if (conf_count >= MAX_MEMBERS) begin
               push_event(gmt_pkg::EV_FULL, id, st, inc, gmt_pkg::AN_NONE, 1'b1);
            end else begin
               conf_id[conf_count] = id;
               conf_count++;
               push_event(gmt_pkg::EV_ADD_CONF, id, gmt_pkg::MS_CONFIRM, inc,
                          gmt_pkg::AN_NONE, 1'b1);
            end
         end else if (act_count >= MAX_MEMBERS) begin
            push_event(gmt_pkg::EV_FULL, id, st, inc, gmt_pkg::AN_NONE, 1'b1);
         end else begin
            act_id[act_count] = id;
            act_status[act_count] = st;
            act_inc[act_count] = inc;
            act_deadline[act_count] = deadline_at(now);
            act_count++;
            push_event(gmt_pkg::EV_ADD_ACT, id, st, inc, gmt_pkg::AN_NONE, 1'b1);
         end
      end else if (id == node_id && st == gmt_pkg::MS_SUSPECT) begin
         // refute suspicion of ourselves
         node_inc = inc + 32'd1;
         act_inc[f] = node_inc;
         act_status[f] = gmt_pkg::MS_ALIVE;
         push_event(gmt_pkg::EV_REFUTED, id, gmt_pkg::MS_ALIVE, node_inc, gmt_pkg::AN_ALIVE,
                    1'b1);
      end else if (st == gmt_pkg::MS_CONFIRM) begin
         retire_member(f);
         push_event(gmt_pkg::EV_MOVED, id, gmt_pkg::MS_CONFIRM, inc, gmt_pkg::AN_CONFIRM, 1'b1);
      end else begin
         if (st == gmt_pkg::MS_ALIVE)
            take = inc > act_inc[f];
         else
            take = (act_status[f] == gmt_pkg::MS_SUSPECT && inc > act_inc[f]) ||
                   (act_status[f] == gmt_pkg::MS_ALIVE && inc >= act_inc[f]);
         if (take) begin
            act_status[f] = st;
            act_inc[f] = inc;
            act_deadline[f] = deadline_at(now);
            push_event(gmt_pkg::EV_UPDATED, id, st, inc, gmt_pkg::AN_NONE, 1'b1);
         end else begin
            push_event(gmt_pkg::EV_NONE, id, act_status[f], act_inc[f], gmt_pkg::AN_NONE,
                       1'b1);
         end
      end
   endtask

   task automatic apply_tick(logic [63:0] now);
      int          i;
      int          k;
      logic [47:0] id;
      logic [31:0] inc;
      i = 0;
      k = 0;
      while (i < act_count) begin
         id = act_id[i];
         inc = act_inc[i];
         if (act_status[i] == gmt_pkg::MS_SUSPECT && act_deadline[i] < now) begin
            retire_member(i);
            if (k < gmt_pkg::RESULT_LIMIT) begin
               push_event(gmt_pkg::EV_MOVED, id, gmt_pkg::MS_CONFIRM, inc, gmt_pkg::AN_CONFIRM,
                          1'b0);
               k++;
            end
         end else begin
            if (k < gmt_pkg::RESULT_LIMIT) begin
               push_event(gmt_pkg::EV_NONE, id, act_status[i], inc, gmt_pkg::AN_NONE, 1'b0);
               k++;
            end
            i++;
         end
      end
      if (k > 0)
         events_due[$].last = 1'b1;
   endtask

   task automatic predict_item();
      int f;
      f = find_member(req_member_id);
      if (req_type == gmt_pkg::REQ_TICK) begin
         apply_tick(req_now_ms);
      end else if (req_type == gmt_pkg::REQ_GOSSIP) begin
         apply_gossip(req_member_id, req_member_status, req_incarnation, req_now_ms);
      end else if (f < 0) begin
         push_event(gmt_pkg::EV_NOT_FOUND, req_member_id, gmt_pkg::MS_ALIVE, '0,
                    gmt_pkg::AN_NONE, 1'b1);
      end else if (req_type == gmt_pkg::REQ_ACK) begin
         push_event(gmt_pkg::EV_UPDATED, req_member_id, gmt_pkg::MS_ALIVE, act_inc[f],
                    act_status[f] == gmt_pkg::MS_SUSPECT ? gmt_pkg::AN_ALIVE : gmt_pkg::AN_NONE,
                    1'b1);
         act_status[f] = gmt_pkg::MS_ALIVE;
         act_deadline[f] = deadline_at(req_now_ms);
      end else if (act_status[f] == gmt_pkg::MS_ALIVE) begin
         act_status[f] = gmt_pkg::MS_SUSPECT;
         act_deadline[f] = deadline_at(req_now_ms);
         push_event(gmt_pkg::EV_UPDATED, req_member_id, gmt_pkg::MS_SUSPECT, act_inc[f],
                    gmt_pkg::AN_SUSPECT, 1'b1);
      end else begin
         push_event(gmt_pkg::EV_NONE, req_member_id, act_status[f], act_inc[f],
                    gmt_pkg::AN_NONE, 1'b1);
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      member_event_type e;
      if (events_due.size() == 0) begin
         $display("%0t: unexpected item, event %0d id %0h", $time, rsp_event_kind,
                  rsp_member_id_res);
         fail_count++;
      end else begin
         e = events_due.pop_front();
         check_field("event_kind", 64'(e.ev), 64'(rsp_event_kind));
         check_field("member_id_res", 64'(e.id), 64'(rsp_member_id_res));
         check_field("member_status_res", 64'(e.status), 64'(rsp_member_status_res));
         check_field("incarnation_res", 64'(e.inc), 64'(rsp_incarnation_res));
         check_field("announce", 64'(e.announce), 64'(rsp_announce));
         check_field("last", 64'(e.last), 64'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         node_id = '0;
         timeout_ms = gmt_pkg::TIMEOUT_RESET;
         act_count = 0;
         conf_count = 0;
         node_inc = '0;
         fail_count = 0;
         events_due.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == gmt_pkg::REG_SELF_ID) node_id = csr_pwdata[47:0];
            else timeout_ms = csr_pwdata[31:0];
         end
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            predict_item();
      end
      pending = events_due.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int  POOL_SIZE   = 40;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  PHASE_ITEMS = 160;
   localparam logic [3:0] ADDR_SELF_ID = 4'd0;
   localparam logic [3:0] ADDR_TIMEOUT = 4'd8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [47:0] req_member_id;
   logic [1:0]  req_member_status;
   logic [31:0] req_incarnation;
   logic [63:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_kind;
   logic [47:0] rsp_member_id_res;
   logic [1:0]  rsp_member_status_res;
   logic [31:0] rsp_incarnation_res;
   logic [1:0]  rsp_announce;
   logic        rsp_last;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_go;
   bit          hold_done;
   int          hold_left;
   logic [63:0] clock_ms;
   logic [47:0] id_pool [POOL_SIZE];
   int          cycles;

   gossip_membership_table uut (.*);

   membership_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // result side: random stalls plus one long hold-off
   initial begin
      rsp_stall = 0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1;
            hold_left--;
         end else if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_left = 300;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom % 100) < recv_idle_pct;
         end
      end
   end

   task automatic write_reg(logic [3:0] addr, logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= addr; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // offer one item and hold it until accepted
   task automatic send_item(logic [1:0] kind, logic [47:0] id, logic [1:0] st,
                            logic [31:0] inc, logic [63:0] now);
      while (($urandom % 100) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= kind; req_member_id <= id; req_member_status <= st;
      req_incarnation <= inc; req_now_ms <= now;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_random();
      logic [1:0]  kind;
      logic [47:0] id;
      logic [1:0]  st;
      logic [31:0] inc;
      logic [63:0] now;
      int          r;
      r = $urandom % 100;
      kind = r < 45 ? gmt_pkg::REQ_GOSSIP : r < 60 ? gmt_pkg::REQ_TICK :
             r < 80 ? gmt_pkg::REQ_ACK : gmt_pkg::REQ_PROBE;
      id = ($urandom % 100) < 85 ? id_pool[$urandom % POOL_SIZE] : 48'({$urandom, $urandom});
      r = $urandom % 100;
      st = r < 5 ? gmt_pkg::MS_INVALID : r < 45 ? gmt_pkg::MS_ALIVE :
           r < 80 ? gmt_pkg::MS_SUSPECT : gmt_pkg::MS_CONFIRM;
      r = $urandom % 100;
      inc = r < 80 ? $urandom_range(0, 7) : r < 90 ? 32'hFFFF_FFFF : $urandom;
      clock_ms = clock_ms + 64'($urandom_range(0, 1500));
      r = $urandom % 100;
      now = r < 3 ? {$urandom, $urandom} : r < 5 ? 64'hFFFF_FFFF_FFFF_FFFF : clock_ms;
      send_item(kind, id, st, inc, now);
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_type = gmt_pkg::REQ_GOSSIP; req_member_id = 0;
      req_member_status = gmt_pkg::MS_ALIVE; req_incarnation = 0; req_now_ms = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      send_idle_pct = 0; recv_idle_pct = 0; hold_go = 0;
      clock_ms = 64'd1000;
      for (int i = 0; i < POOL_SIZE; i++)
         id_pool[i] = 48'({$urandom, $urandom});
      id_pool[38] = '0;
      id_pool[39] = '1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: adds, override rules, refutation, acks, probes, ticks
      write_reg(ADDR_SELF_ID, 64'(id_pool[0]));
      write_reg(ADDR_TIMEOUT, 64'd2000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[0], gmt_pkg::MS_ALIVE, 32'd5, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[1], gmt_pkg::MS_SUSPECT, 32'd3, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[2], gmt_pkg::MS_CONFIRM, 32'd7, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[2], gmt_pkg::MS_ALIVE, 32'd9, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[1], gmt_pkg::MS_INVALID, 32'd4, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[3], gmt_pkg::MS_INVALID, 32'd4, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[0], gmt_pkg::MS_SUSPECT, 32'hFFFF_FFFF,
                64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[1], gmt_pkg::MS_ALIVE, 32'd9, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[1], gmt_pkg::MS_ALIVE, 32'd2, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[1], gmt_pkg::MS_SUSPECT, 32'd9, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[1], gmt_pkg::MS_SUSPECT, 32'd9, 64'd1000);
      send_item(gmt_pkg::REQ_ACK, id_pool[1], gmt_pkg::MS_ALIVE, 32'd0, 64'd1000);
      send_item(gmt_pkg::REQ_ACK, id_pool[4], gmt_pkg::MS_ALIVE, 32'd0, 64'd1000);
      send_item(gmt_pkg::REQ_PROBE, id_pool[1], gmt_pkg::MS_ALIVE, 32'd0, 64'd1000);
      send_item(gmt_pkg::REQ_PROBE, id_pool[1], gmt_pkg::MS_ALIVE, 32'd0, 64'd1000);
      send_item(gmt_pkg::REQ_PROBE, id_pool[5], gmt_pkg::MS_ALIVE, 32'd0, 64'd1000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[3], gmt_pkg::MS_ALIVE, 32'd0,
                64'hFFFF_FFFF_FFFF_FFFF);
      send_item(gmt_pkg::REQ_PROBE, id_pool[3], gmt_pkg::MS_ALIVE, 32'd0,
                64'hFFFF_FFFF_FFFF_FFF0);
      send_item(gmt_pkg::REQ_TICK, '0, gmt_pkg::MS_ALIVE, 32'd0, 64'd1500);
      send_item(gmt_pkg::REQ_TICK, '1, gmt_pkg::MS_INVALID, 32'hFFFF_FFFF, 64'd10000);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[0], gmt_pkg::MS_CONFIRM, 32'd1, 64'd10000);
      send_item(gmt_pkg::REQ_TICK, '0, gmt_pkg::MS_ALIVE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(gmt_pkg::REQ_GOSSIP, id_pool[39], gmt_pkg::MS_SUSPECT, 32'h8000_0000,
                64'd10000);
      settle();

      // sender idles seldom, receiver often
      write_reg(ADDR_TIMEOUT, 64'd0);
      write_reg(ADDR_SELF_ID, 64'(id_pool[1]));
      send_idle_pct = 8; recv_idle_pct = 46;
      repeat (PHASE_ITEMS) send_random();
      settle();

      // the other way round, widest settings
      write_reg(ADDR_TIMEOUT, 64'hFFFF_FFFF);
      write_reg(ADDR_SELF_ID, 64'hFFFF_FFFF_FFFF);
      send_idle_pct = 46; recv_idle_pct = 8;
      repeat (PHASE_ITEMS) send_random();
      settle();

      // no idling, with one long receiver hold-off
      write_reg(ADDR_TIMEOUT, 64'd3000);
      write_reg(ADDR_SELF_ID, 64'(id_pool[2]));
      send_idle_pct = 0; recv_idle_pct = 0;
      hold_go = 1;
      repeat (PHASE_ITEMS) send_random();
      settle();

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
